[rtl/mlt_pkg.sv]
// Shared types, token codes, character constants and keyword lookup for the tokenizer.
package mlt_pkg;

    // Fixed payload widths.
    localparam int KIND_W    = 5;
    localparam int LINE_W    = 16;
    localparam int LEN_OUT_W = 12;
    localparam int KW_MAX    = 7;
    localparam int KW_COUNT  = 9;

    localparam logic [LEN_OUT_W-1:0] LEN_OUT_MAX = '1;
    localparam logic [LINE_W-1:0]    LINE_MAX    = '1;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_DONE    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_ERR     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_ICONST  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RCONST  = 5'd4;
    localparam logic [KIND_W-1:0] KIND_SCONST  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_BCONST  = 5'd6;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_MULT    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_DIV     = 5'd10;
    localparam logic [KIND_W-1:0] KIND_ASSOP   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_EQ      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_GTHAN   = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LTHAN   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_SEMICOL = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd18;
    localparam logic [KIND_W-1:0] KIND_DOT     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_IF      = 5'd20;
    localparam logic [KIND_W-1:0] KIND_ELSE    = 5'd21;
    localparam logic [KIND_W-1:0] KIND_STRING  = 5'd22;
    localparam logic [KIND_W-1:0] KIND_PROGRAM = 5'd23;
    localparam logic [KIND_W-1:0] KIND_AND     = 5'd24;
    localparam logic [KIND_W-1:0] KIND_NOT     = 5'd25;
    localparam logic [KIND_W-1:0] KIND_OR      = 5'd26;

    // Input item codes.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters with a special role.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    // Keywords, text right-aligned so the first letter is the highest byte in use.
    localparam logic [8*KW_MAX-1:0] KW_STR [KW_COUNT] = '{
        56'("if"), 56'("else"), 56'("string"), 56'("program"), 56'("and"),
        56'("not"), 56'("or"), 56'("true"), 56'("false")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd6, 3'd7, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5
    };
    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
        KIND_IF, KIND_ELSE, KIND_STRING, KIND_PROGRAM, KIND_AND,
        KIND_NOT, KIND_OR, KIND_BCONST, KIND_BCONST
    };

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_START,
        MODE_INT,
        MODE_REAL,
        MODE_ID,
        MODE_STR,
        MODE_COLON
    } scan_mode_t;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [LINE_W-1:0]    line;
        logic [LEN_OUT_W-1:0] len;
        logic                 last;
    } tok_res_t;

    // The results of one input item, in order.
    typedef struct packed {
        logic [1:0] cnt;
        tok_res_t   r0;
        tok_res_t   r1;
    } tok_batch_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Single-character operators: hit flag and token kind.
    function automatic logic [KIND_W:0] op_lookup(input logic [7:0] c);
        logic [KIND_W:0] res;
        case (c)
            CH_PLUS:    res = {1'b1, KIND_PLUS};
            CH_MINUS:   res = {1'b1, KIND_MINUS};
            CH_STAR:    res = {1'b1, KIND_MULT};
            CH_SLASH:   res = {1'b1, KIND_DIV};
            CH_EQUAL:   res = {1'b1, KIND_EQ};
            CH_GREATER: res = {1'b1, KIND_GTHAN};
            CH_LESS:    res = {1'b1, KIND_LTHAN};
            CH_COMMA:   res = {1'b1, KIND_COMMA};
            CH_SEMI:    res = {1'b1, KIND_SEMICOL};
            CH_LPAREN:  res = {1'b1, KIND_LPAREN};
            CH_RPAREN:  res = {1'b1, KIND_RPAREN};
            CH_DOT:     res = {1'b1, KIND_DOT};
            default:    res = {1'b0, KIND_ERR};
        endcase
        return res;
    endfunction

    // Kind of a finished word: a keyword, a boolean or a plain identifier.
    function automatic logic [KIND_W-1:0] kw_kind(
        input logic [KW_MAX-1:0][7:0] text,
        input logic [2:0]             len,
        input logic                   fits
    );
        logic [KIND_W-1:0] kind;
        logic              same;
        kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            same = fits && (len == KW_LEN[i]);
            for (int j = 0; j < KW_MAX; j++) begin
                if (j < int'(KW_LEN[i])) begin
                    if (text[j] != KW_STR[i][8*(int'(KW_LEN[i])-1-j) +: 8]) begin
                        same = 1'b0;
                    end
                end
            end
            if (same) begin
                kind = KW_KIND[i];
            end
        end
        return kind;
    endfunction

endpackage

[rtl/mlt_if.sv]
// Handshake interfaces for the character channel and the token channel.
interface mlt_char_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink (input valid, input op, input ch, output ready);
endinterface

interface mlt_tok_if;
    logic                          valid;
    logic                          ready;
    logic [mlt_pkg::KIND_W-1:0]    kind;
    logic [mlt_pkg::LINE_W-1:0]    line;
    logic [mlt_pkg::LEN_OUT_W-1:0] lexeme_length;
    logic                          last;

    modport source (output valid, output kind, output line, output lexeme_length,
                    output last, input ready);
    modport sink (input valid, input kind, input line, input lexeme_length,
                  input last, output ready);
endinterface

[rtl/mlt_scan.sv]
// Scanner: mode, line and length state, word prefix store and per-character transition logic.
module mlt_scan #(
    parameter int KEYWORD_CHARS = 8,
    parameter int LENGTH_BITS   = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_op,
    input  logic [7:0]         item_ch,
    input  logic               room,
    output logic               take,
    output mlt_pkg::tok_batch_t batch
);

    localparam int IDX_W = $clog2(KEYWORD_CHARS);
    localparam int CMP_W = (LENGTH_BITS > mlt_pkg::LEN_OUT_W) ? LENGTH_BITS
                                                               : mlt_pkg::LEN_OUT_W;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    mlt_pkg::scan_mode_t             mode_reg, mode_next;
    logic [mlt_pkg::LINE_W-1:0]      line_reg, line_next;
    logic [LENGTH_BITS-1:0]          tlen_reg, tlen_next;
    logic [7:0]                      prefix_reg [KEYWORD_CHARS];

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_idx;
    logic [LENGTH_BITS-1:0]          tlen_sat;
    logic                            tlen_room;
    logic [mlt_pkg::KW_MAX-1:0][7:0] word_text;
    logic [mlt_pkg::KIND_W-1:0]      word_kind;

    // Start-mode decode of the current character.
    mlt_pkg::scan_mode_t             st_mode;
    logic                            st_first;
    logic                            st_emit;
    logic [mlt_pkg::KIND_W-1:0]      st_kind;
    logic [mlt_pkg::KIND_W:0]        op_hit;

    // Token from the pending lexeme.
    logic                            e0;
    logic [mlt_pkg::KIND_W-1:0]      k0;
    logic [mlt_pkg::LINE_W-1:0]      ln0;
    logic [LENGTH_BITS-1:0]          len0;
    logic                            use_start;
    logic                            done;
    mlt_pkg::tok_res_t               main_res, start_res, done_res;

    function automatic logic [mlt_pkg::LEN_OUT_W-1:0] clamp_len(
        input logic [LENGTH_BITS-1:0] v
    );
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext > CMP_W'(mlt_pkg::LEN_OUT_MAX)) begin
            return mlt_pkg::LEN_OUT_MAX;
        end
        return ext[mlt_pkg::LEN_OUT_W-1:0];
    endfunction

    // Saturating length step and prefix room.
    assign tlen_sat  = (tlen_reg == LEN_MAX) ? tlen_reg : tlen_reg + 1'b1;
    assign tlen_room = {1'b0, tlen_reg} < (LENGTH_BITS+1)'(KEYWORD_CHARS);

    // Keyword compare over the first characters of the word.
    always_comb
    begin
        for (int i = 0; i < mlt_pkg::KW_MAX; i++) begin
            word_text[i] = prefix_reg[i];
        end
    end

    assign word_kind = mlt_pkg::kw_kind(word_text, tlen_reg[2:0],
                                        tlen_reg <= LENGTH_BITS'(mlt_pkg::KW_MAX));

    // What the character does when scanned from the start mode.
    assign op_hit = mlt_pkg::op_lookup(item_ch);

    always_comb
    begin
        st_mode  = mlt_pkg::MODE_START;
        st_first = 1'b0;
        st_emit  = 1'b0;
        st_kind  = mlt_pkg::KIND_ERR;
        if (mlt_pkg::is_digit(item_ch)) begin
            st_mode  = mlt_pkg::MODE_INT;
            st_first = 1'b1;
        end else if (mlt_pkg::is_alpha(item_ch)) begin
            st_mode  = mlt_pkg::MODE_ID;
            st_first = 1'b1;
        end else if (item_ch == mlt_pkg::CH_QUOTE) begin
            st_mode = mlt_pkg::MODE_STR;
        end else if (item_ch == mlt_pkg::CH_COLON) begin
            st_mode = mlt_pkg::MODE_COLON;
        end else if (op_hit[mlt_pkg::KIND_W]) begin
            st_emit = 1'b1;
            st_kind = op_hit[mlt_pkg::KIND_W-1:0];
        end else if (!mlt_pkg::is_space(item_ch) && (item_ch != mlt_pkg::CH_NUL)) begin
            st_emit = 1'b1;
        end
    end

    // Mode transitions, pending token and state update.
    always_comb
    begin
        mode_next = mode_reg;
        tlen_next = tlen_reg;
        line_next = line_reg;
        wr_en     = 1'b0;
        wr_idx    = tlen_reg[IDX_W-1:0];
        e0        = 1'b0;
        k0        = mlt_pkg::KIND_ERR;
        ln0       = line_reg;
        len0      = tlen_reg;
        use_start = 1'b0;
        done      = 1'b0;

        if (item_op == mlt_pkg::OP_END) begin
            done = 1'b1;
            case (mode_reg)
                mlt_pkg::MODE_INT:
                begin
                    e0 = 1'b1;
                    k0 = mlt_pkg::KIND_ICONST;
                end
                mlt_pkg::MODE_REAL:
                begin
                    e0 = 1'b1;
                    k0 = mlt_pkg::KIND_RCONST;
                end
                mlt_pkg::MODE_ID:
                begin
                    e0 = 1'b1;
                    k0 = word_kind;
                end
                mlt_pkg::MODE_STR:
                begin
                    e0   = 1'b1;
                    len0 = tlen_sat;
                end
                mlt_pkg::MODE_COLON:
                begin
                    e0   = 1'b1;
                    len0 = LENGTH_BITS'(1);
                end
                default:
                begin
                    e0 = 1'b0;
                end
            endcase
            mode_next = mlt_pkg::MODE_START;
            tlen_next = '0;
        end else begin
            if ((item_ch == mlt_pkg::CH_NEWLINE) && (line_reg != mlt_pkg::LINE_MAX)) begin
                line_next = line_reg + 1'b1;
            end
            ln0 = line_next;
            case (mode_reg)
                mlt_pkg::MODE_INT:
                begin
                    if (mlt_pkg::is_digit(item_ch) || (item_ch == mlt_pkg::CH_DOT)) begin
                        wr_en     = tlen_room;
                        tlen_next = tlen_sat;
                        if (item_ch == mlt_pkg::CH_DOT) begin
                            mode_next = mlt_pkg::MODE_REAL;
                        end
                    end else begin
                        e0        = 1'b1;
                        k0        = mlt_pkg::KIND_ICONST;
                        use_start = 1'b1;
                    end
                end
                mlt_pkg::MODE_REAL:
                begin
                    if (mlt_pkg::is_digit(item_ch)) begin
                        wr_en     = tlen_room;
                        tlen_next = tlen_sat;
                    end else if (item_ch == mlt_pkg::CH_DOT) begin
                        e0        = 1'b1;
                        len0      = tlen_sat;
                        mode_next = mlt_pkg::MODE_START;
                        tlen_next = '0;
                    end else begin
                        e0        = 1'b1;
                        k0        = mlt_pkg::KIND_RCONST;
                        use_start = 1'b1;
                    end
                end
                mlt_pkg::MODE_ID:
                begin
                    if (mlt_pkg::is_alpha(item_ch) || mlt_pkg::is_digit(item_ch) ||
                        (item_ch == mlt_pkg::CH_UNDERSCORE) ||
                        (item_ch == mlt_pkg::CH_DOLLAR)) begin
                        wr_en     = tlen_room;
                        tlen_next = tlen_sat;
                    end else begin
                        e0        = 1'b1;
                        k0        = word_kind;
                        use_start = 1'b1;
                    end
                end
                mlt_pkg::MODE_STR:
                begin
                    if (item_ch == mlt_pkg::CH_QUOTE) begin
                        e0        = 1'b1;
                        k0        = mlt_pkg::KIND_SCONST;
                        mode_next = mlt_pkg::MODE_START;
                        tlen_next = '0;
                    end else if (item_ch == mlt_pkg::CH_NEWLINE) begin
                        // Unterminated string: reported on the line it started on.
                        e0        = 1'b1;
                        ln0       = line_reg;
                        len0      = tlen_sat;
                        mode_next = mlt_pkg::MODE_START;
                        tlen_next = '0;
                    end else begin
                        tlen_next = tlen_sat;
                    end
                end
                mlt_pkg::MODE_COLON:
                begin
                    if (item_ch == mlt_pkg::CH_EQUAL) begin
                        e0        = 1'b1;
                        k0        = mlt_pkg::KIND_ASSOP;
                        len0      = LENGTH_BITS'(2);
                        mode_next = mlt_pkg::MODE_START;
                        tlen_next = '0;
                    end else begin
                        e0        = 1'b1;
                        len0      = LENGTH_BITS'(1);
                        use_start = 1'b1;
                    end
                end
                default:
                begin
                    use_start = 1'b1;
                end
            endcase

            // The character is scanned again from the start mode.
            if (use_start) begin
                mode_next = st_mode;
                tlen_next = st_first ? LENGTH_BITS'(1) : '0;
                wr_en     = st_first;
                wr_idx    = '0;
            end
        end
    end

    // Order the results of this item.
    always_comb
    begin
        main_res  = '{kind: k0, line: ln0, len: clamp_len(len0), last: 1'b0};
        start_res = '{kind: st_kind, line: line_next,
                      len: mlt_pkg::LEN_OUT_W'(1), last: 1'b0};
        done_res  = '{kind: mlt_pkg::KIND_DONE, line: line_reg, len: '0, last: 1'b0};
        batch     = '0;
        if (e0) begin
            batch.r0 = main_res;
            if (use_start && st_emit) begin
                batch.r1  = start_res;
                batch.cnt = 2'd2;
            end else if (done) begin
                batch.r1  = done_res;
                batch.cnt = 2'd2;
            end else begin
                batch.cnt = 2'd1;
            end
        end else if (use_start && st_emit) begin
            batch.r0  = start_res;
            batch.cnt = 2'd1;
        end else if (done) begin
            batch.r0  = done_res;
            batch.cnt = 2'd1;
        end
        batch.r0.last = (batch.cnt == 2'd1);
        batch.r1.last = 1'b1;
    end

    // An item is taken once its results have a place to go.
    assign take = item_valid && ((batch.cnt == 2'd0) || room);

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= mlt_pkg::MODE_START;
            line_reg <= mlt_pkg::LINE_W'(1);
            tlen_reg <= '0;
        end else if (take) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            tlen_reg <= tlen_next;
        end
    end

    // Word prefix store.
    always_ff @(posedge clk)
    begin
        if (take && wr_en) begin
            prefix_reg[wr_idx] <= item_ch;
        end
    end

    // An end item leaves the scanner in the start mode with no pending length.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && (item_op == mlt_pkg::OP_END) |=>
            (mode_reg == mlt_pkg::MODE_START) && (tlen_reg == '0))
        else $error("scanner state not cleared after end of input");

    // The line count never goes back.
    a_line_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> line_reg >= $past(line_reg))
        else $error("line count decreased");

    // The final result of an end item is DONE.
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && (item_op == mlt_pkg::OP_END) |->
            ((batch.cnt == 2'd1) && (batch.r0.kind == mlt_pkg::KIND_DONE)) ||
            ((batch.cnt == 2'd2) && (batch.r1.kind == mlt_pkg::KIND_DONE)))
        else $error("end of input without DONE");

endmodule

[rtl/mlt_out.sv]
// Result register: holds the one or two tokens of an item and hands them out in order.
module mlt_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mlt_pkg::tok_batch_t batch,
    output logic                room,
    mlt_tok_if.source           tok_chan
);

    logic [1:0]        cnt_reg, cnt_next;
    mlt_pkg::tok_res_t r0_reg, r0_next;
    mlt_pkg::tok_res_t r1_reg, r1_next;
    logic              pop;

    assign pop  = tok_chan.valid && tok_chan.ready;
    assign room = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && tok_chan.ready);

    // Load a new pair, or move the second token up after a transaction.
    always_comb
    begin
        cnt_next = cnt_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        if (load) begin
            cnt_next = batch.cnt;
            r0_next  = batch.r0;
            r1_next  = batch.r1;
        end else if (pop) begin
            cnt_next = cnt_reg - 1'b1;
            r0_next  = r1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

    // Token channel drive.
    assign tok_chan.valid         = (cnt_reg != 2'd0);
    assign tok_chan.kind          = r0_reg.kind;
    assign tok_chan.line          = r0_reg.line;
    assign tok_chan.lexeme_length = r0_reg.len;
    assign tok_chan.last          = r0_reg.last;

    // A pair is loaded only over an empty or emptying register.
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop))
        else $error("result register overwritten");

    // The first of two waiting tokens is never marked last.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !r0_reg.last && r1_reg.last)
        else $error("last flag out of order");

    // A single waiting token always closes its item.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> r0_reg.last)
        else $error("lone token not marked last");

endmodule

[rtl/mini_language_tokenizer.sv]
// Top level of the tokenizer: character input register, scanner and result register.
// The tokenizer takes one character per clock while the result register has room and
// passes each through an input register, the scanner logic and a result register, so the
// first token of a character appears once both registers have been loaded in turn. The
// result register holds the one or two tokens a character causes and sends one per cycle
// while the token channel is ready; a character that closes a pending token and starts
// another, or an end item that flushes a token before DONE, therefore fills both places
// of the result register and holds up the next character that causes a token.
// Characters that cause no token never wait on the output. Keywords are recognized by
// comparing the first KW_MAX characters of a word in parallel; lexeme lengths count in
// LENGTH_BITS bits and saturate.
module mini_language_tokenizer #(
    parameter int KEYWORD_CHARS = 8,
    parameter int LENGTH_BITS   = 12
) (
    input logic        clk,
    input logic        rst_n,
    mlt_char_if.sink   char_chan,
    mlt_tok_if.source  tok_chan
);

    logic                in_valid_reg, in_valid_next;
    logic                in_op_reg;
    logic [7:0]          in_ch_reg;
    logic                take;
    logic                room;
    logic                accept;
    mlt_pkg::tok_batch_t batch;

    // The input register refills in the cycle its item moves on.
    assign char_chan.ready = !in_valid_reg || take;
    assign accept          = char_chan.valid && char_chan.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_op_reg <= char_chan.op;
            in_ch_reg <= char_chan.ch;
        end
    end

    mlt_scan #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_op    (in_op_reg),
        .item_ch    (in_ch_reg),
        .room       (room),
        .take       (take),
        .batch      (batch)
    );

    mlt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && (batch.cnt != 2'd0)),
        .batch    (batch),
        .room     (room),
        .tok_chan (tok_chan)
    );

    // An item leaves the input register only if it was there.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> in_valid_reg)
        else $error("scanner took an empty input register");

    // A held character waits only on the result register.
    a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !take |-> !room && (batch.cnt != 2'd0))
        else $error("input register stalled without cause");

    // A new transaction is never lost over a waiting character.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !in_valid_reg || take)
        else $error("input register overrun");

endmodule
